[hdl/fes_pkg.sv]
// Types and constants shared by the fade envelope sequencer.
`timescale 1ns / 1ps

package fes_pkg;

    // Envelope phase as reported on the result word.
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_FADE_IN  = 2'd1,
        PH_HOLD     = 2'd2,
        PH_FADE_OUT = 2'd3
    } phase_t;

    // Sequencer steps of the shared multiply and divide datapath.
    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_EVAL,
        SQ_SQR,
        SQ_SQD,
        SQ_DEN,
        SQ_DIV,
        SQ_SCALE,
        SQ_MULP,
        SQ_ALPHA,
        SQ_FIN
    } seq_t;

    // Command codes carried in the input word.
    localparam logic [1:0] FUNC_SHOW = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_HIDE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_PEAK     = 2'd0;
    localparam logic [1:0] CFG_FADE_IN  = 2'd1;
    localparam logic [1:0] CFG_HOLD     = 2'd2;
    localparam logic [1:0] CFG_FADE_OUT = 2'd3;

    // Register reset values.
    localparam logic [7:0]  PEAK_RESET     = 8'd255;
    localparam logic [15:0] FADE_IN_RESET  = 16'd150;
    localparam logic [15:0] HOLD_RESET     = 16'd1000;
    localparam logic [15:0] FADE_OUT_RESET = 16'd300;

    // Pop scale in unsigned Q1.15: 1.0 and floor(0.8 * 32768).
    localparam logic [15:0] SCALE_ONE   = 16'd32768;
    localparam logic [15:0] SCALE_START = 16'd26214;

    // Number of quotient bits the divider produces.
    localparam int DIV_STEPS = 16;

endpackage

[hdl/fade_envelope_sequencer_unit.sv]
// Opacity envelope sequencer with a shared multiplier and bit-serial divider.
`timescale 1ns / 1ps

// Show, hide, hold and ignored words pass from the evaluate step to the result step,
// a running fade-out tick adds one 16-step division, a running fade-in tick two.
// A new input word is taken only from the idle step, after the previous result has
// been loaded into the result register; the 16-step restoring divider sets the pace.
// Reset: rst_n clears the control and envelope state at once; registers return to their
// reset values.
module fade_envelope_sequencer_unit
    import fes_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] now_ms, [32] sticky, [39:33] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] present, [8:1] alpha, [24:9] scale_q15,
                                   // [25] shown, [27:26] phase_out, [28] ticking,
                                   // [31:29] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [7:0]  peak_reg;
    logic [15:0] fin_reg;
    logic [15:0] hold_reg;
    logic [15:0] fout_reg;

    // Sequencer.
    seq_t state_reg, state_next;

    // Captured input word.
    logic [1:0]            func_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  sticky_in_reg;

    // Envelope state.
    phase_t                phase_reg;
    logic [TIME_WIDTH-1:0] start_reg;
    logic                  visible_reg;
    logic                  sticky_reg;
    logic                  timer_reg;
    logic [15:0]           scale_reg;

    // Working registers of the shared datapath.
    logic [15:0] dur_reg;
    logic [15:0] r_reg;
    logic [15:0] mop_reg;
    logic [31:0] prod_reg;
    logic [34:0] rem_reg;
    logic [15:0] lo_reg;
    logic [34:0] divisor_reg;
    logic [3:0]  cnt_reg;
    logic        div_scale_reg;
    logic        res_present_reg;
    logic [7:0]  res_alpha_reg;

    // Result register.
    logic        m_valid_reg;
    logic [31:0] m_data_reg;

    logic                  in_accept;
    logic                  cfg_write;
    logic                  out_load;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [15:0]           e16;
    logic                  ge_in;
    logic                  ge_out;
    logic                  ge_hold;
    logic                  tick_live;
    logic                  in_run;
    logic                  out_run;
    logic [15:0]           mul_a;
    logic [15:0]           mul_b;
    logic [31:0]           mul_p;
    logic [36:0]           div_diff;
    logic                  div_borrow;

    assign in_accept = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // The result register frees as soon as the previous word is taken.
    assign out_load = (state_reg == SQ_FIN) && (!m_valid_reg || m_tready);

    // Elapsed time wraps with the time counter; a backwards step ends the phase.
    assign elapsed = now_reg - start_reg;
    assign e16     = elapsed[15:0];
    assign ge_in   = elapsed >= TIME_WIDTH'(fin_reg);
    assign ge_out  = elapsed >= TIME_WIDTH'(fout_reg);
    assign ge_hold = elapsed >= TIME_WIDTH'(hold_reg);

    assign tick_live = (func_reg == FUNC_TICK) && timer_reg && visible_reg;
    assign in_run    = tick_live && (phase_reg == PH_FADE_IN) && !ge_in;
    assign out_run   = tick_live && (phase_reg == PH_FADE_OUT) && !ge_out;

    // Shared 16 by 16 multiplier, operands chosen by the sequencer step.
    always_comb
    begin
        unique case (state_reg)
            SQ_SQR:
            begin
                mul_a = r_reg;
                mul_b = r_reg;
            end
            SQ_SQD:
            begin
                mul_a = dur_reg;
                mul_b = dur_reg;
            end
            default:
            begin
                mul_a = {8'd0, peak_reg};
                mul_b = mop_reg;
            end
        endcase
    end

    assign mul_p = 32'(mul_a) * 32'(mul_b);

    // One restoring division step: shift in the next dividend bit and try to subtract.
    assign div_diff   = {1'b0, rem_reg, lo_reg[15]} - {2'b00, divisor_reg};
    assign div_borrow = div_diff[36];

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            SQ_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = SQ_EVAL;
                end
            end
            SQ_EVAL:
            begin
                priority if (in_run)
                begin
                    state_next = SQ_SQR;
                end
                else if (out_run)
                begin
                    state_next = SQ_MULP;
                end
                else
                begin
                    state_next = SQ_FIN;
                end
            end
            SQ_SQR:   state_next = SQ_SQD;
            SQ_SQD:   state_next = SQ_DEN;
            SQ_DEN:   state_next = SQ_DIV;
            SQ_DIV:
            begin
                if (cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    state_next = div_scale_reg ? SQ_SCALE : SQ_ALPHA;
                end
            end
            SQ_SCALE: state_next = SQ_MULP;
            SQ_MULP:  state_next = SQ_DIV;
            SQ_ALPHA: state_next = SQ_FIN;
            SQ_FIN:
            begin
                if (out_load)
                begin
                    state_next = SQ_IDLE;
                end
            end
            default:  state_next = SQ_IDLE;
        endcase
    end

    // Configuration, envelope state and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg    <= PEAK_RESET;
            fin_reg     <= FADE_IN_RESET;
            hold_reg    <= HOLD_RESET;
            fout_reg    <= FADE_OUT_RESET;
            phase_reg   <= PH_IDLE;
            start_reg   <= '0;
            visible_reg <= 1'b0;
            sticky_reg  <= 1'b0;
            timer_reg   <= 1'b0;
            scale_reg   <= SCALE_ONE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (paddr[3:2])
                    CFG_PEAK:     peak_reg <= pwdata[7:0];
                    CFG_FADE_IN:  fin_reg  <= pwdata[15:0];
                    CFG_HOLD:     hold_reg <= pwdata[15:0];
                    CFG_FADE_OUT: fout_reg <= pwdata[15:0];
                endcase
            end

            if (state_reg == SQ_EVAL)
            begin
                priority case (func_reg)
                    FUNC_SHOW:
                    begin
                        sticky_reg  <= sticky_in_reg;
                        scale_reg   <= SCALE_START;
                        phase_reg   <= PH_FADE_IN;
                        start_reg   <= now_reg;
                        visible_reg <= 1'b1;
                        timer_reg   <= 1'b1;
                    end
                    FUNC_HIDE:
                    begin
                        timer_reg   <= 1'b0;
                        phase_reg   <= PH_IDLE;
                        visible_reg <= 1'b0;
                        sticky_reg  <= 1'b0;
                    end
                    FUNC_TICK:
                    begin
                        if (timer_reg && visible_reg)
                        begin
                            unique case (phase_reg)
                                PH_FADE_IN:
                                begin
                                    // Fade-in over: the new phase starts at this tick.
                                    if (ge_in)
                                    begin
                                        phase_reg <= PH_HOLD;
                                        start_reg <= now_reg;
                                        scale_reg <= SCALE_ONE;
                                    end
                                end
                                PH_HOLD:
                                begin
                                    priority if (sticky_reg)
                                    begin
                                        timer_reg <= 1'b0;
                                    end
                                    else if (ge_hold)
                                    begin
                                        phase_reg <= PH_FADE_OUT;
                                        start_reg <= now_reg;
                                    end
                                end
                                PH_FADE_OUT:
                                begin
                                    if (ge_out)
                                    begin
                                        timer_reg   <= 1'b0;
                                        phase_reg   <= PH_IDLE;
                                        visible_reg <= 1'b0;
                                        sticky_reg  <= 1'b0;
                                    end
                                end
                                PH_IDLE:
                                begin
                                    timer_reg <= 1'b0;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        // The unused code leaves the state alone.
                    end
                endcase
            end

            // Ease-out scale: 1.0 minus the rounded-up quotient of 32768*r^2 / 5*dur^2.
            if (state_reg == SQ_SCALE)
            begin
                scale_reg <= SCALE_ONE - lo_reg - {15'd0, rem_reg != '0};
            end

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg      <= s_tuser;
            now_reg       <= TIME_WIDTH'(s_tdata[31:0]);
            sticky_in_reg <= s_tdata[32];
        end

        unique case (state_reg)
            SQ_EVAL:
            begin
                res_present_reg <= 1'b0;
                res_alpha_reg   <= 8'd0;
                r_reg           <= fin_reg - e16;
                if (func_reg == FUNC_SHOW)
                begin
                    res_present_reg <= 1'b1;
                end
                else if (tick_live)
                begin
                    unique case (phase_reg)
                        PH_FADE_IN:
                        begin
                            res_present_reg <= 1'b1;
                            res_alpha_reg   <= peak_reg;
                            dur_reg         <= fin_reg;
                            mop_reg         <= e16;
                        end
                        PH_HOLD:
                        begin
                            res_present_reg <= 1'b1;
                            res_alpha_reg   <= peak_reg;
                        end
                        PH_FADE_OUT:
                        begin
                            res_present_reg <= !ge_out;
                            dur_reg         <= fout_reg;
                            mop_reg         <= fout_reg - e16;
                        end
                        PH_IDLE:
                        begin
                            res_present_reg <= 1'b0;
                        end
                    endcase
                end
            end
            SQ_SQR:
            begin
                // Dividend 32768*r^2, split into the upper remainder and lower bits.
                rem_reg <= {4'd0, mul_p[31:1]};
                lo_reg  <= {mul_p[0], 15'd0};
            end
            SQ_SQD:
            begin
                prod_reg <= mul_p;
            end
            SQ_DEN:
            begin
                divisor_reg   <= {1'b0, prod_reg, 2'b00} + {3'd0, prod_reg};
                cnt_reg       <= '0;
                div_scale_reg <= 1'b1;
            end
            SQ_DIV:
            begin
                if (!div_borrow)
                begin
                    rem_reg <= div_diff[34:0];
                end
                else
                begin
                    rem_reg <= {rem_reg[33:0], lo_reg[15]};
                end
                lo_reg  <= {lo_reg[14:0], !div_borrow};
                cnt_reg <= cnt_reg + 4'd1;
            end
            SQ_MULP:
            begin
                // Dividend peak times the ramp position, divided by the duration.
                rem_reg       <= {19'd0, mul_p[31:16]};
                lo_reg        <= mul_p[15:0];
                divisor_reg   <= {19'd0, dur_reg};
                cnt_reg       <= '0;
                div_scale_reg <= 1'b0;
            end
            SQ_ALPHA:
            begin
                res_alpha_reg <= lo_reg[7:0];
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            m_data_reg <= {3'd0, timer_reg, phase_reg, visible_reg, scale_reg,
                           res_alpha_reg, res_present_reg};
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3:2])
            CFG_PEAK:     prdata = {24'd0, peak_reg};
            CFG_FADE_IN:  prdata = {16'd0, fin_reg};
            CFG_HOLD:     prdata = {16'd0, hold_reg};
            CFG_FADE_OUT: prdata = {16'd0, fout_reg};
        endcase
    end

`ifndef SYNTHESIS
    // A word is taken only from the idle step, so ready drops right after.
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("input accepted while a word is in progress");

    // The divider runs its full count without leaving the step.
    a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_DIV && cnt_reg != 4'(DIV_STEPS - 1)) |=> state_reg == SQ_DIV)
        else $error("division cut short");

    // The scale stays between 0.8 and 1.0.
    a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        (scale_reg >= SCALE_START) && (scale_reg <= SCALE_ONE))
        else $error("scale out of range");

    // The indicator is visible exactly while a phase other than idle runs.
    a_visible_phase: assert property (@(posedge clk) disable iff (!rst_n)
        visible_reg == (phase_reg != PH_IDLE))
        else $error("visibility and phase disagree");

    // The timer never runs for a hidden indicator.
    a_timer_visible: assert property (@(posedge clk) disable iff (!rst_n)
        timer_reg |-> visible_reg)
        else $error("timer running while hidden");
`endif

endmodule

[tb/tb_fade_envelope_sequencer_unit.sv]
// Self-checking testbench for the fade envelope sequencer: scripted and random words.
`timescale 1ns / 1ps

// The bench drives command words into the input stream and checks every result word
// against a cycle-free predictor of the opacity envelope kept inside the bench.
// A short script comes first. It covers reset behavior, every command, the unused
// command code, time wrap, time going backwards, sticky hold, hide during fade-in,
// and the ends of both ramps. Randomized episodes follow under six register settings.
// Each episode is a show followed by ticks that walk forward in time, with some noise
// mixed in. Both stream sides stall at random, and at one point the result side holds
// off long enough to back the block up into its input.
module tb_fade_envelope_sequencer_unit;
    import fes_pkg::*;

    // The fourth command code has no meaning and must be ignored by the block.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // The slowest word is a running fade-in tick. Stalls on both sides, the long hold-off,
    // and the quiet periods around register writes stay well inside this limit.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 60;
    localparam int NUM_SETTINGS    = 6;

    // One result word split into its fields.
    typedef struct packed {
        logic        present;
        logic [7:0]  alpha;
        logic [15:0] scale_q15;
        logic        shown;
        phase_t      phase_out;
        logic        ticking;
    } frame_t;

    // One line of the directed script. The expected frame is used only when typed is set.
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic        sticky;
        logic        typed;
        frame_t      want;
    } script_row_t;

    // One register setting: peak, fade-in, hold, fade-out.
    typedef struct packed {
        logic [7:0]  peak;
        logic [15:0] fade_in;
        logic [15:0] hold;
        logic [15:0] fade_out;
    } setting_t;

    // Frames that can be read straight off the envelope with the reset registers in place.
    localparam frame_t IDLE_FRAME    = '{1'b0, 8'd0, SCALE_ONE, 1'b0, PH_IDLE, 1'b0};
    localparam frame_t SHOW_FRAME    = '{1'b1, 8'd0, SCALE_START, 1'b1, PH_FADE_IN, 1'b1};
    localparam frame_t PEAK_FRAME    = '{1'b1, 8'd255, SCALE_ONE, 1'b1, PH_HOLD, 1'b1};
    localparam frame_t OUT_ENTRY     = '{1'b1, 8'd255, SCALE_ONE, 1'b1, PH_FADE_OUT, 1'b1};
    localparam frame_t STICKY_STOP   = '{1'b1, 8'd255, SCALE_ONE, 1'b1, PH_HOLD, 1'b0};
    localparam frame_t STOPPED_FRAME = '{1'b0, 8'd0, SCALE_ONE, 1'b1, PH_HOLD, 1'b0};

    // The script runs with the reset registers: peak 255, fade-in 150, hold 1000, and
    // fade-out 300.
    localparam script_row_t SCRIPT [25] = '{
        '{FUNC_TICK,   32'd0,          1'b0, 1'b1, IDLE_FRAME},    // tick with timer off
        '{FUNC_UNUSED, 32'hFFFF_FFFF,  1'b1, 1'b1, IDLE_FRAME},    // unused code
        '{FUNC_HIDE,   32'd0,          1'b0, 1'b1, IDLE_FRAME},    // hide when idle
        '{FUNC_SHOW,   32'd1000,       1'b0, 1'b1, SHOW_FRAME},
        '{FUNC_TICK,   32'd1075,       1'b0, 1'b0, IDLE_FRAME},    // fade-in midpoint
        '{FUNC_TICK,   32'd1149,       1'b1, 1'b0, IDLE_FRAME},    // last fade-in step
        '{FUNC_TICK,   32'd1150,       1'b0, 1'b1, PEAK_FRAME},    // fade-in complete
        '{FUNC_TICK,   32'd2149,       1'b0, 1'b1, PEAK_FRAME},    // hold one ms short
        '{FUNC_TICK,   32'd2150,       1'b0, 1'b1, OUT_ENTRY},     // hold expires
        '{FUNC_TICK,   32'd2300,       1'b0, 1'b0, IDLE_FRAME},    // fade-out midpoint
        '{FUNC_TICK,   32'd2449,       1'b0, 1'b0, IDLE_FRAME},    // last fade-out step
        '{FUNC_TICK,   32'd2450,       1'b0, 1'b1, IDLE_FRAME},    // fade-out ends
        '{FUNC_TICK,   32'd2460,       1'b1, 1'b1, IDLE_FRAME},    // timer already off
        '{FUNC_SHOW,   32'hFFFF_FFF0,  1'b1, 1'b1, SHOW_FRAME},    // sticky show
        '{FUNC_TICK,   32'h0000_0010,  1'b0, 1'b0, IDLE_FRAME},    // time wraps through 0
        '{FUNC_TICK,   32'hFFFF_FFE0,  1'b0, 1'b1, PEAK_FRAME},    // time goes backwards
        '{FUNC_TICK,   32'd6,          1'b0, 1'b1, STICKY_STOP},   // sticky hold stops
        '{FUNC_TICK,   32'd7,          1'b0, 1'b1, STOPPED_FRAME}, // ignored, still shown
        '{FUNC_HIDE,   32'd7,          1'b1, 1'b1, IDLE_FRAME},
        '{FUNC_SHOW,   32'd100,        1'b0, 1'b1, SHOW_FRAME},
        '{FUNC_TICK,   32'd130,        1'b0, 1'b0, IDLE_FRAME},
        '{FUNC_HIDE,   32'd131,        1'b0, 1'b0, IDLE_FRAME},    // hide keeps scale
        '{FUNC_SHOW,   32'd200,        1'b1, 1'b1, SHOW_FRAME},
        '{FUNC_TICK,   32'd200,        1'b0, 1'b0, IDLE_FRAME},    // zero elapsed
        '{FUNC_HIDE,   32'hFFFF_FFFF,  1'b0, 1'b0, IDLE_FRAME}
    };

    // The random part goes through register settings that include both extremes:
    // all durations zero with no peak, and all durations at maximum with full peak.
    localparam setting_t SETTINGS [NUM_SETTINGS] = '{
        '{8'd0,   16'd0,     16'd0,     16'd0},
        '{8'd255, 16'd65535, 16'd65535, 16'd65535},
        '{8'd128, 16'd16,    16'd40,    16'd25},
        '{8'd1,   16'd1,     16'd0,     16'd1},
        '{8'd77,  16'd300,   16'd5,     16'd0},
        '{8'd200, 16'd7,     16'd3000,  16'd200}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [31:0] now_ms, [32] sticky, [39:33] zero
    logic [1:0]  s_tuser;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [0] present, [8:1] alpha, [24:9] scale_q15, [25] shown,
                            // [27:26] phase_out, [28] ticking, [31:29] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // The predictor keeps its own copy of the registers and envelope state.
    logic [7:0]  cfg_peak;
    logic [15:0] cfg_fade_in;
    logic [15:0] cfg_hold;
    logic [15:0] cfg_fade_out;
    phase_t      env_phase;
    logic [31:0] env_start;
    logic        env_visible;
    logic        env_sticky;
    logic        env_timer;
    logic [15:0] env_scale;

    frame_t      pending_frames [$];
    int          words_sent;
    int          frames_checked;
    int          mismatches;
    int          cycle_count;
    int          presented [4];
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_off_req;

    fade_envelope_sequencer_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hide, and the end of fade-out, drop the indicator and stop the timer.
    // The pop scale is left where it was.
    function automatic void clear_envelope();
        env_timer   = 1'b0;
        env_phase   = PH_IDLE;
        env_visible = 1'b0;
        env_sticky  = 1'b0;
    endfunction

    // Advances the envelope by one command word and returns the frame that the word yields.
    function automatic frame_t next_frame(logic [1:0] func, logic [31:0] now, logic stk);
        frame_t            f;
        logic [31:0]       elapsed;
        longint unsigned   dur;
        longint unsigned   level;
        longint unsigned   rest;
        longint unsigned   num;
        longint unsigned   den;
        f.present = 1'b0;
        level     = 0;
        elapsed   = now - env_start;   // wraps modulo 2^32
        if (func == FUNC_SHOW)
        begin
            env_sticky  = stk;
            env_scale   = SCALE_START;
            env_phase   = PH_FADE_IN;
            env_start   = now;
            env_visible = 1'b1;
            env_timer   = 1'b1;
            f.present   = 1'b1;
        end
        else if (func == FUNC_HIDE)
        begin
            clear_envelope();
        end
        else if (func == FUNC_TICK && env_timer && env_visible)
        begin
            case (env_phase)
                PH_FADE_IN:
                begin
                    dur = cfg_fade_in;
                    if (dur == 0 || elapsed >= dur)
                    begin
                        env_phase = PH_HOLD;
                        env_start = now;
                        env_scale = SCALE_ONE;
                        level     = cfg_peak;
                    end
                    else
                    begin
                        // Ease-out quad from 0.8 to 1.0, rounded toward 0.8.
                        rest      = dur - elapsed;
                        num       = 64'd32768 * rest * rest;
                        den       = 64'd5 * dur * dur;
                        env_scale = 16'(64'd32768 - (num + den - 1) / den);
                        level     = (cfg_peak * longint'(elapsed)) / dur;
                    end
                    f.present = 1'b1;
                end
                PH_HOLD:
                begin
                    level     = cfg_peak;
                    f.present = 1'b1;
                    if (env_sticky)
                        env_timer = 1'b0;
                    else if (elapsed >= cfg_hold)
                    begin
                        env_phase = PH_FADE_OUT;
                        env_start = now;
                    end
                end
                PH_FADE_OUT:
                begin
                    dur = cfg_fade_out;
                    if (dur == 0 || elapsed >= dur)
                        clear_envelope();
                    else
                    begin
                        level     = (cfg_peak * (dur - elapsed)) / dur;
                        f.present = 1'b1;
                    end
                end
                default:
                begin
                    env_timer = 1'b0;
                end
            endcase
        end
        f.alpha     = !f.present ? 8'd0 : (level > 255 ? 8'd255 : level[7:0]);
        f.scale_q15 = env_scale;
        f.shown     = env_visible;
        f.phase_out = env_phase;
        f.ticking   = env_timer;
        return f;
    endfunction

    // The bench offers one command word and waits until the block accepts it.
    // The caller stands at a falling edge, and the task returns at a falling edge.
    // The sender may first idle for a random number of cycles.
    task automatic send_word(logic [1:0] func, logic [31:0] now, logic stk,
                             logic typed, frame_t want);
        int     gap;
        frame_t model;
        gap = 0;
        while (gap < 25 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, stk, now};
        s_tuser  <= func;
        do
            @(posedge clk);
        while (!s_tready);
        model = next_frame(func, now, stk);
        pending_frames.push_back(typed ? want : model);
        words_sent++;
        // The sender idles lightly while the receiver stalls heavily, then the roles
        // swap, and at the end neither side idles.
        if (words_sent < 150)
        begin
            tx_idle_pct = 9;
            rx_idle_pct = 65;
        end
        else if (words_sent < 290)
        begin
            tx_idle_pct = 65;
            rx_idle_pct = 9;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        @(negedge clk);
    endtask

    // Writes one register, reads it back, and updates the predictor's copy.
    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== value)
        begin
            $display("%0t: register %0d read back expected %0h actual %0h",
                     $time, idx, value, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            CFG_PEAK:     cfg_peak     = value[7:0];
            CFG_FADE_IN:  cfg_fade_in  = value[15:0];
            CFG_HOLD:     cfg_hold     = value[15:0];
            CFG_FADE_OUT: cfg_fade_out = value[15:0];
        endcase
    endtask

    // Registers change only after the block has returned every word that it owes and has had
    // time to settle.
    task automatic drain_results();
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random episodes. Each episode is a show followed by ticks that walk forward in time.
    // Noise is mixed in: ticks at random times, steps back in time, unused codes, hides,
    // and restarts.
    task automatic run_episodes(int n_words, int step_max);
        logic [31:0] t;
        int          count;
        int          len;
        int          pick;
        t     = $urandom;
        count = 0;
        while (count < n_words)
        begin
            send_word(FUNC_SHOW, t, ($urandom_range(0, 3) == 0), 1'b0, IDLE_FRAME);
            count++;
            len = $urandom_range(3, 14);
            repeat (len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 78)
                begin
                    t += $urandom_range(0, step_max);
                    send_word(FUNC_TICK, t, 1'($urandom_range(0, 1)), 1'b0, IDLE_FRAME);
                end
                else if (pick < 84)
                    send_word(FUNC_TICK, $urandom, 1'($urandom_range(0, 1)), 1'b0,
                              IDLE_FRAME);
                else if (pick < 89)
                begin
                    t -= $urandom_range(1, step_max);
                    send_word(FUNC_TICK, t, 1'($urandom_range(0, 1)), 1'b0, IDLE_FRAME);
                end
                else if (pick < 93)
                    send_word(FUNC_UNUSED, $urandom, 1'($urandom_range(0, 1)), 1'b0,
                              IDLE_FRAME);
                else if (pick < 97)
                    send_word(FUNC_HIDE, t, 1'($urandom_range(0, 1)), 1'b0, IDLE_FRAME);
                else
                    send_word(FUNC_SHOW, t, 1'($urandom_range(0, 1)), 1'b0, IDLE_FRAME);
                count++;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                send_word(FUNC_HIDE, t, 1'($urandom_range(0, 1)), 1'b0, IDLE_FRAME);
                count++;
            end
        end
    endtask

    // The receiver stalls at random. On request it holds off for a long stretch, so the
    // block fills up and stops taking new words.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // The checker compares each accepted result word with the oldest expected frame.
    always @(posedge clk)
    begin
        frame_t got;
        frame_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.present   = m_tdata[0];
            got.alpha     = m_tdata[8:1];
            got.scale_q15 = m_tdata[24:9];
            got.shown     = m_tdata[25];
            got.phase_out = phase_t'(m_tdata[27:26]);
            got.ticking   = m_tdata[28];
            if (pending_frames.size() == 0)
            begin
                $display("%0t: result word with none expected, actual %0h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_frames.pop_front();
                if (got !== want)
                begin
                    $display("%0t: result %0d expected present %0b alpha %0d scale %0d ",
                             $time, frames_checked, want.present, want.alpha,
                             want.scale_q15,
                             "shown %0b phase %0d ticking %0b",
                             want.shown, want.phase_out, want.ticking);
                    $display("%0t: result %0d actual   present %0b alpha %0d scale %0d ",
                             $time, frames_checked, got.present, got.alpha, got.scale_q15,
                             "shown %0b phase %0d ticking %0b",
                             got.shown, got.phase_out, got.ticking);
                    mismatches++;
                end
            end
            if (got.present === 1'b1)
                presented[got.phase_out]++;
            frames_checked++;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_fade_envelope_sequencer_unit NOT OK");
            $finish;
        end
    end

    initial
    begin
        int i;
        int step_max;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = FUNC_HIDE;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        words_sent     = 0;
        frames_checked = 0;
        mismatches     = 0;
        cycle_count    = 0;
        presented      = '{0, 0, 0, 0};
        tx_idle_pct    = 9;
        rx_idle_pct    = 65;
        hold_off_req   = 1'b0;
        cfg_peak       = PEAK_RESET;
        cfg_fade_in    = FADE_IN_RESET;
        cfg_hold       = HOLD_RESET;
        cfg_fade_out   = FADE_OUT_RESET;
        env_phase      = PH_IDLE;
        env_start      = '0;
        env_visible    = 1'b0;
        env_sticky     = 1'b0;
        env_timer      = 1'b0;
        env_scale      = SCALE_ONE;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The script runs on the reset register values.
        for (i = 0; i < 25; i++)
            send_word(SCRIPT[i].func, SCRIPT[i].now_ms, SCRIPT[i].sticky,
                      SCRIPT[i].typed, SCRIPT[i].want);

        for (i = 0; i < NUM_SETTINGS; i++)
        begin
            s_tvalid <= 1'b0;
            drain_results();
            write_register(CFG_PEAK, {24'd0, SETTINGS[i].peak});
            write_register(CFG_FADE_IN, {16'd0, SETTINGS[i].fade_in});
            write_register(CFG_HOLD, {16'd0, SETTINGS[i].hold});
            write_register(CFG_FADE_OUT, {16'd0, SETTINGS[i].fade_out});
            // The time steps scale with the longest duration. This way each episode
            // reaches every phase within a few ticks.
            step_max = SETTINGS[i].fade_in;
            if (SETTINGS[i].hold > step_max)
                step_max = SETTINGS[i].hold;
            if (SETTINGS[i].fade_out > step_max)
                step_max = SETTINGS[i].fade_out;
            step_max = step_max / 3 + 3;
            if (i == 2)
                hold_off_req = 1'b1;
            run_episodes(66, step_max);
        end

        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Run covered %0d command words under %0d register settings; %0d results",
                 words_sent, NUM_SETTINGS + 1, frames_checked);
        $display("Frames presented in fade-in %0d, hold %0d, fade-out %0d; %0d mismatches.",
                 presented[PH_FADE_IN], presented[PH_HOLD], presented[PH_FADE_OUT],
                 mismatches);
        if (mismatches == 0)
            $display("tb_fade_envelope_sequencer_unit OK");
        else
            $display("tb_fade_envelope_sequencer_unit NOT OK");
        $finish;
    end

endmodule
